FILE: rtl/core/btp_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Pipeline geometry, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package btp_pkg;

  // One quotient bit per divider stage.
  localparam int unsigned DivStages = 64;
  // Thirteen stages ahead of the divider, the divider, eight stages after it.
  localparam int unsigned PipeDepth = 13 + DivStages + 8;
  // Temperature result is formed in stage 5 and rides to stage PipeDepth-1.
  localparam int unsigned TcLen     = PipeDepth - 5;
  // Divisor-nonzero flag is formed in stage 13.
  localparam int unsigned OkLen     = PipeDepth - 13;

  localparam logic [1:0] REG_TEMP_COEFFS  = 2'd0;
  localparam logic [1:0] REG_PRESS_A      = 2'd1;
  localparam logic [1:0] REG_PRESS_B      = 2'd2;
  localparam logic [1:0] REG_PRESS_NINE   = 2'd3;

  localparam logic [24:0]        PRESS_MAX    = 25'h1FF_FFFF;
  localparam logic [20:0]        PRESS_OFFSET = 21'd1048576;
  localparam logic signed [26:0] TFINE_OFFSET = 27'sd128000;
  localparam logic [11:0]        PRESS_SCALE  = 12'd3125;
  localparam logic [63:0]        PRESS_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic signed [28:0] TEMP_ROUND   = 29'sd128;
  localparam logic signed [28:0] TEMP_MUL     = 29'sd5;

endpackage

FILE: rtl/core/baro_temp_press_compensation.sv
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// Fully pipelined 64-bit integer compensation of raw temperature and
// pressure samples, with calibration words held in APB registers.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not held. Its
// depth is set by the signed 64-bit division, which runs as 64 restoring
// stages of one quotient bit each; wide products are cut into 32-bit partial
// products in stages of their own. When the result at the output is held,
// the whole pipeline holds with it and s_axis_tready_o drops; no item is
// lost or repeated. Calibration words must be written through APB only while
// no item is in flight; the block itself does not enforce this.
module baro_temp_press_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [19:0] raw_pressure, [39:20] raw_temperature
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] temp_centideg, [40:16] pressure_q24_8
  output logic [0:0]  m_axis_tuser_o    // [0] press_valid
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_coeffs_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [15:0] press_nine_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_nine_q  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        btp_pkg::REG_TEMP_COEFFS: temp_coeffs_q <= pwdata[47:0];
        btp_pkg::REG_PRESS_A:     press_a_q     <= pwdata;
        btp_pkg::REG_PRESS_B:     press_b_q     <= pwdata;
        btp_pkg::REG_PRESS_NINE:  press_nine_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      btp_pkg::REG_TEMP_COEFFS: prdata = {16'd0, temp_coeffs_q};
      btp_pkg::REG_PRESS_A:     prdata = press_a_q;
      btp_pkg::REG_PRESS_B:     prdata = press_b_q;
      btp_pkg::REG_PRESS_NINE:  prdata = {48'd0, press_nine_q};
      default:                  prdata = '0;
    endcase
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs_q[15:0];
  assign t2 = $signed(temp_coeffs_q[31:16]);
  assign t3 = $signed(temp_coeffs_q[47:32]);
  assign p1 = press_a_q[15:0];
  assign p2 = $signed(press_a_q[31:16]);
  assign p3 = $signed(press_a_q[47:32]);
  assign p4 = $signed(press_a_q[63:48]);
  assign p5 = $signed(press_b_q[15:0]);
  assign p6 = $signed(press_b_q[31:16]);
  assign p7 = $signed(press_b_q[47:32]);
  assign p8 = $signed(press_b_q[63:48]);
  assign p9 = $signed(press_nine_q);

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output holds.
  // --------------------------------------------------------------------------
  logic [btp_pkg::PipeDepth-1:0] vld_q;
  logic                          en;

  assign en              = !vld_q[btp_pkg::PipeDepth-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[btp_pkg::PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[btp_pkg::PipeDepth-2:0], s_axis_tvalid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage logic
  // --------------------------------------------------------------------------
  // Stage 1
  logic signed [17:0] d1_d, d1_q;
  logic signed [16:0] d2_d, d2_q;
  logic        [20:0] pr1_d, pr1_q;
  // Stage 2
  logic signed [33:0] m1_d, m1_q;
  logic signed [33:0] m2_full;
  logic        [31:0] m2_q;
  logic        [20:0] pr2_q;
  // Stage 3
  logic signed [22:0] a1_q;
  logic signed [36:0] m3_d, m3_q;
  logic        [20:0] pr3_q;
  // Stage 4
  logic signed [25:0] tf_d, tf_q;
  logic        [20:0] pr4_q;
  // Stage 5
  logic signed [28:0] t5;
  logic signed [20:0] tsh;
  logic        [15:0] tc_d;
  logic signed [26:0] v1_d, v1_q;
  logic        [20:0] pr5_q;
  // Stage 6
  logic signed [53:0] vv_d;
  logic        [53:0] vv_q;
  logic signed [42:0] vp5_d, vp5_q, vp2_d, vp2_q;
  logic        [20:0] pr6_q;
  // Stage 7
  logic signed [48:0] pp6l_d, pp6l_q, pp3l_d, pp3l_q;
  logic signed [38:0] pp6h_full, pp3h_full;
  logic        [31:0] pp6h_q, pp3h_q;
  logic        [63:0] c7_d, c7_q;
  logic signed [42:0] vp2_7_q;
  logic        [20:0] pr7_q;
  // Stage 8
  logic        [63:0] v2_d, v2_q, x3_d, x3_q;
  logic signed [42:0] vp2_8_q;
  logic        [20:0] pr8_q;
  // Stage 9
  logic        [63:0] v1b_d, v1b_q, n0_d, n0_q;
  // Stage 10
  logic        [63:0] y_q;
  logic        [43:0] nl_d, nl_q, nh_full;
  logic        [31:0] nh_q;
  // Stage 11
  logic        [47:0] yl_d, yl_q, yh_full;
  logic        [31:0] yh_q;
  logic        [63:0] num_d, num_q;
  // Stage 12
  logic        [63:0] prod12;
  logic        [30:0] v1f_q;
  logic        [63:0] num12_q;
  // Stage 13
  logic               neg13_q;
  logic        [63:0] mn_q;
  logic        [30:0] md13_q;
  logic               ok_d;

  always_comb begin
    d1_d  = $signed({1'b0, s_axis_tdata_i[39:23]}) - $signed({1'b0, t1, 1'b0});
    d2_d  = $signed({1'b0, s_axis_tdata_i[39:24]}) - $signed({1'b0, t1});
    pr1_d = btp_pkg::PRESS_OFFSET - {1'b0, s_axis_tdata_i[19:0]};

    m1_d    = d1_q * t2;
    m2_full = d2_q * d2_q;

    m3_d = $signed({1'b0, m2_q[31:12]}) * t3;

    tf_d = 26'(a1_q) + 26'($signed(m3_q[36:14]));

    t5  = 29'(tf_q) * btp_pkg::TEMP_MUL + btp_pkg::TEMP_ROUND;
    tsh = t5[28:8];
    if (tsh < -21'sd32768) begin
      tc_d = 16'h8000;
    end else if (tsh > 21'sd32767) begin
      tc_d = 16'h7FFF;
    end else begin
      tc_d = tsh[15:0];
    end
    v1_d = 27'(tf_q) - btp_pkg::TFINE_OFFSET;

    vv_d  = v1_q * v1_q;
    vp5_d = v1_q * p5;
    vp2_d = v1_q * p2;

    // Products with the 54-bit square split at bit 32; only the low word of
    // the upper partial product survives the 64-bit wrap.
    pp6l_d    = $signed({1'b0, vv_q[31:0]}) * p6;
    pp6h_full = $signed({1'b0, vv_q[53:32]}) * p6;
    pp3l_d    = $signed({1'b0, vv_q[31:0]}) * p3;
    pp3h_full = $signed({1'b0, vv_q[53:32]}) * p3;
    c7_d      = (64'(vp5_q) << 17) + (64'(p4) << 35);

    v2_d = 64'(pp6l_q) + {pp6h_q, 32'd0} + c7_q;
    x3_d = 64'(pp3l_q) + {pp3h_q, 32'd0};

    v1b_d = 64'($signed(x3_q) >>> 8) + (64'(vp2_8_q) << 12);
    n0_d  = {12'd0, pr8_q, 31'd0} - v2_q;

    nl_d    = n0_q[31:0] * btp_pkg::PRESS_SCALE;
    nh_full = n0_q[63:32] * btp_pkg::PRESS_SCALE;

    yl_d    = y_q[31:0] * p1;
    yh_full = y_q[63:32] * p1;
    num_d   = {20'd0, nl_q} + {nh_q, 32'd0};

    prod12 = {16'd0, yl_q} + {yh_q, 32'd0};

    ok_d = (v1f_q != 31'd0);
  end

  // --------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage. The dividend word shifts
  // out at the top while quotient bits shift in at the bottom.
  // --------------------------------------------------------------------------
  logic [63:0] dq_q   [btp_pkg::DivStages];
  logic [30:0] rem_q  [btp_pkg::DivStages];
  logic [30:0] dmd_q  [btp_pkg::DivStages];
  logic        dneg_q [btp_pkg::DivStages];
  logic [63:0] dq_d   [btp_pkg::DivStages];
  logic [30:0] rem_d  [btp_pkg::DivStages];
  logic [30:0] dmd_in [btp_pkg::DivStages];
  logic        dneg_in[btp_pkg::DivStages];
  logic [63:0] dq_in  [btp_pkg::DivStages];
  logic [30:0] rem_in [btp_pkg::DivStages];
  logic [31:0] trial  [btp_pkg::DivStages];
  logic [31:0] diff   [btp_pkg::DivStages];

  always_comb begin
    for (int k = 0; k < btp_pkg::DivStages; k++) begin
      if (k == 0) begin
        dq_in[k]   = mn_q;
        rem_in[k]  = '0;
        dmd_in[k]  = md13_q;
        dneg_in[k] = neg13_q;
      end else begin
        dq_in[k]   = dq_q[k-1];
        rem_in[k]  = rem_q[k-1];
        dmd_in[k]  = dmd_q[k-1];
        dneg_in[k] = dneg_q[k-1];
      end
      trial[k] = {rem_in[k], dq_in[k][63]};
      diff[k]  = trial[k] - {1'b0, dmd_in[k]};
      if (trial[k] >= {1'b0, dmd_in[k]}) begin
        rem_d[k] = diff[k][30:0];
        dq_d[k]  = {dq_in[k][62:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][30:0];
        dq_d[k]  = {dq_in[k][62:0], 1'b0};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages after the divider
  // --------------------------------------------------------------------------
  logic        [63:0] pq_d, pq_q;
  logic        [63:0] q13;
  logic        [63:0] ll_d, ll_q, lh_full;
  logic        [31:0] lh_q;
  logic signed [48:0] e2l_d, e2l_q, e2h_full;
  logic        [31:0] e2h_q;
  logic        [63:0] pq2_q;
  logic        [63:0] sq_d, sq_q, e2p_d, e2p_q;
  logic        [63:0] pq3_q;
  logic signed [48:0] s9l_d, s9l_q, s9h_full;
  logic        [31:0] s9h_q;
  logic        [63:0] e2_d, e2_q, pq4_q;
  logic        [63:0] e1p, e1_d, e1_q, e2_5_q, pq5_q;
  logic        [63:0] s_d, s_q;
  logic        [63:0] r_d, r_q;
  logic        [24:0] pres_d, pres_q;
  logic        [15:0] tc_out_q;
  logic               ok_out_q;

  logic [15:0] tc_line_q [btp_pkg::TcLen];
  logic        ok_line_q [btp_pkg::OkLen];

  always_comb begin
    pq_d = dneg_q[btp_pkg::DivStages-1] ? (64'd0 - dq_q[btp_pkg::DivStages-1])
                                        : dq_q[btp_pkg::DivStages-1];

    q13      = 64'($signed(pq_q) >>> 13);
    ll_d     = q13[31:0] * q13[31:0];
    lh_full  = q13[31:0] * q13[63:32];
    e2l_d    = $signed({1'b0, pq_q[31:0]}) * p8;
    e2h_full = $signed({1'b0, pq_q[63:32]}) * p8;

    // Square modulo 2^64: low*low plus twice the cross term above bit 32.
    sq_d  = ll_q + {lh_q[30:0], 33'd0};
    e2p_d = 64'(e2l_q) + {e2h_q, 32'd0};

    s9l_d    = $signed({1'b0, sq_q[31:0]}) * p9;
    s9h_full = $signed({1'b0, sq_q[63:32]}) * p9;
    e2_d     = 64'($signed(e2p_q) >>> 19);

    e1p  = 64'(s9l_q) + {s9h_q, 32'd0};
    e1_d = 64'($signed(e1p) >>> 25);

    s_d = pq5_q + e1_q + e2_5_q;

    r_d = 64'($signed(s_q) >>> 8) + (64'(p7) << 4);

    if (!ok_line_q[btp_pkg::OkLen-1] || r_q[63]) begin
      pres_d = '0;
    end else if (r_q > {39'd0, btp_pkg::PRESS_MAX}) begin
      pres_d = btp_pkg::PRESS_MAX;
    end else begin
      pres_d = r_q[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      pr1_q <= pr1_d;

      m1_q  <= m1_d;
      m2_q  <= m2_full[31:0];
      pr2_q <= pr1_q;

      a1_q  <= m1_q[33:11];
      m3_q  <= m3_d;
      pr3_q <= pr2_q;

      tf_q  <= tf_d;
      pr4_q <= pr3_q;

      v1_q  <= v1_d;
      pr5_q <= pr4_q;

      vv_q  <= vv_d;
      vp5_q <= vp5_d;
      vp2_q <= vp2_d;
      pr6_q <= pr5_q;

      pp6l_q  <= pp6l_d;
      pp6h_q  <= pp6h_full[31:0];
      pp3l_q  <= pp3l_d;
      pp3h_q  <= pp3h_full[31:0];
      c7_q    <= c7_d;
      vp2_7_q <= vp2_q;
      pr7_q   <= pr6_q;

      v2_q    <= v2_d;
      x3_q    <= x3_d;
      vp2_8_q <= vp2_7_q;
      pr8_q   <= pr7_q;

      v1b_q <= v1b_d;
      n0_q  <= n0_d;

      y_q  <= v1b_q + btp_pkg::PRESS_BIAS;
      nl_q <= nl_d;
      nh_q <= nh_full[31:0];

      yl_q  <= yl_d;
      yh_q  <= yh_full[31:0];
      num_q <= num_d;

      v1f_q   <= prod12[63:33];
      num12_q <= num_q;

      neg13_q <= num12_q[63] ^ v1f_q[30];
      mn_q    <= num12_q[63] ? (64'd0 - num12_q) : num12_q;
      md13_q  <= v1f_q[30] ? (31'd0 - v1f_q) : v1f_q;

      for (int k = 0; k < btp_pkg::DivStages; k++) begin
        dq_q[k]   <= dq_d[k];
        rem_q[k]  <= rem_d[k];
        dmd_q[k]  <= dmd_in[k];
        dneg_q[k] <= dneg_in[k];
      end

      pq_q <= pq_d;

      ll_q  <= ll_d;
      lh_q  <= lh_full[31:0];
      e2l_q <= e2l_d;
      e2h_q <= e2h_full[31:0];
      pq2_q <= pq_q;

      sq_q  <= sq_d;
      e2p_q <= e2p_d;
      pq3_q <= pq2_q;

      s9l_q <= s9l_d;
      s9h_q <= s9h_full[31:0];
      e2_q  <= e2_d;
      pq4_q <= pq3_q;

      e1_q   <= e1_d;
      e2_5_q <= e2_q;
      pq5_q  <= pq4_q;

      s_q <= s_d;
      r_q <= r_d;

      pres_q   <= pres_d;
      tc_out_q <= tc_line_q[btp_pkg::TcLen-1];
      ok_out_q <= ok_line_q[btp_pkg::OkLen-1];

      tc_line_q[0] <= tc_d;
      for (int i = 1; i < btp_pkg::TcLen; i++) begin
        tc_line_q[i] <= tc_line_q[i-1];
      end
      ok_line_q[0] <= ok_d;
      for (int i = 1; i < btp_pkg::OkLen; i++) begin
        ok_line_q[i] <= ok_line_q[i-1];
      end
    end
  end

  assign m_axis_tdata_o = {7'd0, pres_q, tc_out_q};
  assign m_axis_tuser_o = ok_out_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw temperature and pressure samples under several calibration sets,
// predicts each result in 64-bit integer arithmetic unless the row gives it,
// and checks each output item against it, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic signed [15:0] temp_cdeg;
    logic [24:0]        press_q;
    logic               press_ok;
  } comp_t;

  typedef struct {
    int unsigned set_idx;   // calibration set the row runs under
    logic [19:0] raw_p;
    logic [19:0] raw_t;
    bit          typed;     // expected result given in the row
    comp_t       want;
  } stim_row_t;

  localparam int unsigned NumRandom = 1280;
  localparam int unsigned Drain     = btp_pkg::PipeDepth + 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  // Calibration currently loaded in the block.
  logic [47:0] temp_coeffs_q  = '0;
  logic [63:0] press_a_q      = '0;
  logic [63:0] press_b_q      = '0;
  logic [15:0] press_nine_q   = '0;

  comp_t       pending_q[$];
  int unsigned n_errors = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;

  always #4 clk_i = ~clk_i;

  baro_temp_press_compensation u_dut (.*);

  function automatic longint sx16(logic [63:0] v, int unsigned pos);
    return longint'(signed'(v[pos +: 16]));
  endfunction

  function automatic comp_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d1, d2, t_fine, tc, v1, v2, num, p, q, e1, e2;
    comp_t r;
    t1 = longint'(temp_coeffs_q[15:0]);
    t2 = sx16(temp_coeffs_q, 16);
    t3 = sx16(temp_coeffs_q, 32);
    p1 = longint'(press_a_q[15:0]);
    p2 = sx16(press_a_q, 16);
    p3 = sx16(press_a_q, 32);
    p4 = sx16(press_a_q, 48);
    p5 = sx16(press_b_q, 0);
    p6 = sx16(press_b_q, 16);
    p7 = sx16(press_b_q, 32);
    p8 = sx16(press_b_q, 48);
    p9 = sx16(64'(press_nine_q), 0);

    d1 = longint'(raw_t >> 3) - (t1 << 1);
    d2 = longint'(raw_t >> 4) - t1;
    t_fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    tc = (t_fine * 5 + 128) >>> 8;
    if (tc < -32768) tc = -32768;
    else if (tc > 32767) tc = 32767;
    r.temp_cdeg = tc[15:0];

    v1 = t_fine - 128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((longint'(1) << 47) + v1) * p1) >>> 33;

    r.press_q  = '0;
    r.press_ok = 1'b0;
    if (v1 != 0) begin
      num = (((longint'(1048576) - longint'(raw_p)) << 31) - v2) * 3125;
      // The one overflowing quotient wraps back to the most negative value.
      if (num == 64'sh8000_0000_0000_0000 && v1 == -1) p = num;
      else p = num / v1;
      q  = p >>> 13;
      e1 = (p9 * q * q) >>> 25;
      e2 = (p8 * p) >>> 19;
      p  = ((p + e1 + e2) >>> 8) + (p7 << 4);
      if (p < 0) r.press_q = '0;
      else if (p > longint'(btp_pkg::PRESS_MAX)) r.press_q = btp_pkg::PRESS_MAX;
      else r.press_q = p[24:0];
      r.press_ok = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Output side: random stalls, checks at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.temp_cdeg = m_axis_tdata_o[15:0];
      got.press_q   = m_axis_tdata_o[40:16];
      got.press_ok  = m_axis_tuser_o[0];
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (got.temp_cdeg != want.temp_cdeg)
          report_mismatch("temp_centideg", got.temp_cdeg, want.temp_cdeg);
        if (got.press_q != want.press_q)
          report_mismatch("pressure_q24_8", got.press_q, want.press_q);
        if (got.press_ok != want.press_ok)
          report_mismatch("press_valid", got.press_ok, want.press_ok);
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      btp_pkg::REG_TEMP_COEFFS: temp_coeffs_q = val[47:0];
      btp_pkg::REG_PRESS_A:     press_a_q     = val;
      btp_pkg::REG_PRESS_B:     press_b_q     = val;
      default:                  press_nine_q  = val[15:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Loads a calibration set once the pipeline has drained.
  task automatic load_calibration(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                                  logic [63:0] p9);
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
    apb_write(btp_pkg::REG_TEMP_COEFFS, {16'($urandom), tc});
    apb_write(btp_pkg::REG_PRESS_A, pa);
    apb_write(btp_pkg::REG_PRESS_B, pb);
    apb_write(btp_pkg::REG_PRESS_NINE, p9);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(logic [19:0] raw_p, logic [19:0] raw_t, bit typed,
                             comp_t want);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {raw_t, raw_p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q.push_back(typed ? want : compensate(raw_p, raw_t));
    @(negedge clk_i);
  endtask

  task automatic load_set(int unsigned k);
    case (k)
      // Typical sensor calibration.
      1: load_calibration({-16'sd1000, 16'sd26435, 16'd27504},
                          {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
                          {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140}, 64'sd6000);
      // Largest coefficients.
      2: load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF},
                          {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                          {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
      // Most negative signed coefficients.
      3: load_calibration({16'h8000, 16'h8000, 16'h0000},
                          {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                          {16'h8000, 16'h8000, 16'h8000, 16'h8000},
                          64'hFFFF_FFFF_FFFF_8000);
      default: ;
    endcase
  endtask

  stim_row_t dir_rows[] = '{
    // After reset all coefficients are zero: temperature 0, pressure invalid.
    '{0, 20'h00000, 20'h00000, 1, '{16'sd0, 25'd0, 1'b0}},
    '{0, 20'hFFFFF, 20'hFFFFF, 1, '{16'sd0, 25'd0, 1'b0}},
    '{0, 20'hAAAAA, 20'h55555, 1, '{16'sd0, 25'd0, 1'b0}},
    '{0, 20'h55555, 20'hAAAAA, 1, '{16'sd0, 25'd0, 1'b0}},
    '{1, 20'd415148, 20'd519888, 0, '0},
    '{1, 20'h00000, 20'h00000, 0, '0},
    '{1, 20'hFFFFF, 20'hFFFFF, 0, '0},
    '{1, 20'h00000, 20'hFFFFF, 0, '0},
    '{1, 20'hFFFFF, 20'h00000, 0, '0},
    '{1, 20'd300000, 20'd600000, 0, '0},
    '{2, 20'h00000, 20'h00000, 0, '0},
    '{2, 20'hFFFFF, 20'hFFFFF, 0, '0},
    '{2, 20'd415148, 20'd519888, 0, '0},
    '{2, 20'h80000, 20'h7FFFF, 0, '0},
    '{3, 20'h00000, 20'h00000, 0, '0},
    '{3, 20'hFFFFF, 20'hFFFFF, 0, '0},
    '{3, 20'd415148, 20'd519888, 0, '0},
    '{3, 20'h7FFFF, 20'h80000, 0, '0}
  };

  function automatic logic [15:0] nudge(int signed base, int unsigned span);
    return 16'(base + $signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  initial begin
    int unsigned cur_set, phase, per_phase, kind;
    logic [19:0] rp, rt;
    logic [63:0] pa, pb;
    cur_set = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    snd_idle = 35; rcv_idle = 61;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_idx != cur_set) begin
        cur_set = dir_rows[i].set_idx;
        load_set(cur_set);
      end
      send_sample(dir_rows[i].raw_p, dir_rows[i].raw_t, dir_rows[i].typed,
                  dir_rows[i].want);
    end

    per_phase = NumRandom / 12;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin snd_idle = 61; rcv_idle = 35; end
      if (phase == 8) begin snd_idle = 0;  rcv_idle = 0;  end
      kind = phase % 4;
      if (kind == 3) begin
        // Fully random calibration; pressure is often invalid or saturated.
        pa = {$urandom, $urandom};
        if (phase == 3) pa[15:0] = '0;
        load_calibration({16'($urandom), 16'($urandom), 16'($urandom)}, pa,
                         {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        load_calibration({nudge(-1000, 500), nudge(26435, 2000), 16'(nudge(27504, 2000))},
                         {nudge(2855, 400), nudge(3024, 400), nudge(-10685, 800),
                          16'(nudge(36477, 2000))},
                         {nudge(-14600, 800), nudge(15500, 800), nudge(-7, 20),
                          nudge(140, 40)},
                         {48'($urandom), nudge(6000, 500)});
      end
      repeat (per_phase) begin
        if ($urandom_range(1)) begin
          rp = 20'($urandom); rt = 20'($urandom);
        end else begin
          rp = 20'(415148 + $signed($urandom_range(65535)) - 32768);
          rt = 20'(519888 + $signed($urandom_range(65535)) - 32768);
        end
        send_sample(rp, rt, 0, '0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
